// File: hw/rtl/irrc_pkg.sv
package irrc_pkg;

   // Event kinds carried on the request tuser field.
   localparam logic [1:0] EVENT_FRAME = 2'd0;
   localparam logic [1:0] EVENT_TICK  = 2'd1;
   localparam logic [1:0] EVENT_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_ADDR      = 2'd0;
   localparam logic [1:0] CSR_PROG_ADDR       = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS   = 2'd2;
   localparam logic [1:0] CSR_LEARN_THRESHOLD = 2'd3;

   // RC5 command codes of the remote keys.
   localparam logic [6:0] KEY_FWD_LEFT  = 7'd1;
   localparam logic [6:0] KEY_FWD       = 7'd2;
   localparam logic [6:0] KEY_FWD_RIGHT = 7'd3;
   localparam logic [6:0] KEY_LEFT      = 7'd4;
   localparam logic [6:0] KEY_REV       = 7'd5;
   localparam logic [6:0] KEY_RIGHT     = 7'd6;
   localparam logic [6:0] KEY_REV_ALT   = 7'd8;
   localparam logic [6:0] KEY_LEARN     = 7'd9;
   localparam logic [6:0] KEY_VOL_UP    = 7'd16;
   localparam logic [6:0] KEY_VOL_DOWN  = 7'd17;

   localparam logic [3:0] SPEED_MAX   = 4'd10;
   localparam logic [3:0] SPEED_MIN   = 4'd1;
   localparam logic [3:0] SPEED_RESET = 4'd4;

   localparam logic [4:0]  START_ADDR_RESET      = 5'd11;
   localparam logic [4:0]  PROG_ADDR_RESET       = 5'd7;
   localparam logic [15:0] TIMEOUT_TICKS_RESET   = 16'd200;
   localparam logic [7:0]  LEARN_THRESHOLD_RESET = 8'd5;

   typedef enum logic [1:0] {
      SM_POWER       = 2'd0,
      SM_STARTED     = 2'd1,
      SM_STOPPED     = 2'd2,
      SM_PROGRAMMING = 2'd3
   } start_state_type;

   typedef enum logic [2:0] {
      DRIVE_STOP      = 3'd0,
      DRIVE_FWD       = 3'd1,
      DRIVE_REV       = 3'd2,
      DRIVE_RIGHT     = 3'd3,
      DRIVE_LEFT      = 3'd4,
      DRIVE_FWD_LEFT  = 3'd5,
      DRIVE_FWD_RIGHT = 3'd6
   } drive_mode_type;

   typedef struct packed {
      logic [4:0]  start_addr;
      logic [4:0]  prog_addr;
      logic [15:0] timeout_ticks;
      logic [7:0]  learn_threshold;
   } cfg_type;

   typedef struct packed {
      start_state_type start_state;
      logic [6:0]      start_code;
      drive_mode_type  drive;
      logic [15:0]     timeout;
      logic [3:0]      speed;
      logic [4:0]      remote_addr;
      logic [7:0]      learn_count;
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]        start_status;
      logic [2:0]        drive_mode;
      logic              drive_active;
      logic signed [5:0] left_drive;
      logic signed [5:0] right_drive;
      logic [3:0]        speed_setting;
   } result_type;

endpackage

// File: hw/rtl/irrc_event_logic.sv
module irrc_event_logic (
   input  irrc_pkg::cfg_type        cfg,
   input  irrc_pkg::ctrl_state_type state_cur,
   input  logic [1:0]               event_kind,
   input  logic [4:0]               rc5_address,
   input  logic [6:0]               rc5_command,
   output irrc_pkg::ctrl_state_type state_next,
   output irrc_pkg::result_type     result
);
   import irrc_pkg::*;

   drive_mode_type    key_drive;
   logic              key_is_drive;
   logic signed [5:0] full_pos;
   logic signed [5:0] half_pos;

   // Drive key decode.
   always_comb begin
      key_drive    = DRIVE_STOP;
      key_is_drive = 1'b1;
      unique case (rc5_command) inside
         KEY_FWD_LEFT:         key_drive = DRIVE_FWD_LEFT;
         KEY_FWD:              key_drive = DRIVE_FWD;
         KEY_FWD_RIGHT:        key_drive = DRIVE_FWD_RIGHT;
         KEY_LEFT:             key_drive = DRIVE_LEFT;
         KEY_RIGHT:            key_drive = DRIVE_RIGHT;
         KEY_REV, KEY_REV_ALT: key_drive = DRIVE_REV;
         default:              key_is_drive = 1'b0;
      endcase
   end

   // State update for one event.
   always_comb begin
      state_next = state_cur;
      case (event_kind)
         EVENT_FRAME: begin
            if (rc5_address == cfg.start_addr) begin
               if (rc5_command == (state_cur.start_code | 7'd1)) begin
                  state_next.start_state = SM_STARTED;
               end else if (rc5_command == {state_cur.start_code[6:1], 1'b0}) begin
                  state_next.start_state = SM_STOPPED;
               end
            end else if (rc5_address == cfg.prog_addr) begin
               state_next.start_code = rc5_command;
               if (state_cur.start_state != SM_STOPPED) begin
                  state_next.start_state = SM_PROGRAMMING;
               end
            end

            if (rc5_address == state_cur.remote_addr) begin
               if (key_is_drive) begin
                  state_next.drive   = key_drive;
                  state_next.timeout = cfg.timeout_ticks;
               end
               if (rc5_command == KEY_VOL_UP && state_cur.speed < SPEED_MAX) begin
                  state_next.speed = state_cur.speed + 4'd1;
               end
               if (rc5_command == KEY_VOL_DOWN && state_cur.speed > SPEED_MIN) begin
                  state_next.speed = state_cur.speed - 4'd1;
               end
            end

            // Holding key 9 long enough teaches the sender's address.
            if (rc5_command == KEY_LEARN) begin
               if (state_cur.learn_count > cfg.learn_threshold) begin
                  state_next.remote_addr = rc5_address;
                  state_next.learn_count = 8'd0;
               end else begin
                  state_next.learn_count = state_cur.learn_count + 8'd1;
               end
            end else begin
               state_next.learn_count = 8'd0;
            end
         end
         EVENT_TICK: begin
            if (state_cur.timeout != 16'd0) begin
               state_next.timeout = state_cur.timeout - 16'd1;
            end
         end
         EVENT_CLEAR: begin
            state_next.start_state = SM_POWER;
         end
         default: begin
         end
      endcase
   end

   // Wheel drive from the updated state.
   assign full_pos = {1'b0, state_next.speed, 1'b0};
   assign half_pos = {2'b00, state_next.speed};

   always_comb begin
      result.start_status  = state_next.start_state;
      result.drive_mode    = state_next.drive;
      result.drive_active  = (state_next.timeout != 16'd0);
      result.speed_setting = state_next.speed;
      result.left_drive    = 6'sd0;
      result.right_drive   = 6'sd0;
      if (result.drive_active) begin
         case (state_next.drive)
            DRIVE_FWD: begin
               result.left_drive  = full_pos;
               result.right_drive = full_pos;
            end
            DRIVE_REV: begin
               result.left_drive  = -full_pos;
               result.right_drive = -full_pos;
            end
            DRIVE_RIGHT: begin
               result.left_drive  = half_pos;
               result.right_drive = -half_pos;
            end
            DRIVE_LEFT: begin
               result.left_drive  = -half_pos;
               result.right_drive = half_pos;
            end
            DRIVE_FWD_LEFT: begin
               result.left_drive  = half_pos;
               result.right_drive = full_pos;
            end
            DRIVE_FWD_RIGHT: begin
               result.left_drive  = full_pos;
               result.right_drive = half_pos;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/ir_remote_start_and_drive_control_core.sv
// RC5 remote start module and remote drive controller. Each request transfer is
// one event: a decoded RC5 frame, one time tick, or a host clear of the start
// state. Every event yields exactly one response transfer carrying the start
// status, the drive mode, whether the drive timeout is still running, the left
// and right wheel drive in twentieths of full power, and the speed level in
// tenths. The block takes one event per clock cycle while the response side
// takes responses; an event is captured in an input register at its request
// transfer and its response is loaded into the output register once that
// register is free. The state update for one event is a single pass of logic
// between those two registers, which is what lets the next event follow
// immediately. When the response side holds off, the two registers hold
// two events and the request side then stalls until a response is taken.
// The configuration port is always ready and must only be written while no
// event is in flight.
module ir_remote_start_and_drive_control_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [4:0] rc5_address, [11:5] rc5_command
   input  logic [1:0]  req_tuser,  // [1:0] mode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [1:0] start_status, [4:2] drive_mode,
                                   // [5] drive_active, [11:6] left_drive,
                                   // [17:12] right_drive, [21:18] speed_setting
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import irrc_pkg::*;

   cfg_type        cfg_ff;
   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   result_type     result_in;
   result_type     result_ff;

   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [4:0] in_addr_ff;
   logic [6:0] in_cmd_ff;
   logic       out_valid_ff;
   logic       out_free;
   logic       advance;

   // The output register can take a new result when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_addr      <= START_ADDR_RESET;
         cfg_ff.prog_addr       <= PROG_ADDR_RESET;
         cfg_ff.timeout_ticks   <= TIMEOUT_TICKS_RESET;
         cfg_ff.learn_threshold <= LEARN_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_ADDR:      cfg_ff.start_addr      <= csr_wdata[4:0];
            CSR_PROG_ADDR:       cfg_ff.prog_addr       <= csr_wdata[4:0];
            CSR_TIMEOUT_TICKS:   cfg_ff.timeout_ticks   <= csr_wdata;
            CSR_LEARN_THRESHOLD: cfg_ff.learn_threshold <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: holds one event until the output side can accept it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_addr_ff <= req_tdata[4:0];
         in_cmd_ff  <= req_tdata[11:5];
      end
   end

   irrc_event_logic u_event_logic (
      .cfg         (cfg_ff),
      .state_cur   (state_ff),
      .event_kind  (in_kind_ff),
      .rc5_address (in_addr_ff),
      .rc5_command (in_cmd_ff),
      .state_next  (state_in),
      .result      (result_in)
   );

   // Controller state moves only when an event passes to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.start_state <= SM_POWER;
         state_ff.start_code  <= 7'd0;
         state_ff.drive       <= DRIVE_STOP;
         state_ff.timeout     <= 16'd0;
         state_ff.speed       <= SPEED_RESET;
         state_ff.remote_addr <= 5'd0;
         state_ff.learn_count <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        result_ff.speed_setting,
                        result_ff.right_drive,
                        result_ff.left_drive,
                        result_ff.drive_active,
                        result_ff.drive_mode,
                        result_ff.start_status};

endmodule
